// ===== rtl/core/nta_pkg.sv =====
// shared constants, table entry types and the controller/datapath command and status structs
// for the neighbor table with aging; no dependencies
`default_nettype none

package nta_pkg;

    // table geometry
    localparam int NBR_SLOTS    = 16;
    localparam int VEC_SLOTS    = 32;
    localparam int VEC_BYTES    = 7;
    localparam int PARAM_FIELDS = 7;

    // field widths
    localparam int BYTE_W = 8;
    localparam int ID_W   = 8;
    localparam int TICK_W = 32;
    localparam int DIST_W = 8;

    // derived widths
    localparam int NBR_AW     = (NBR_SLOTS > 1) ? $clog2(NBR_SLOTS) : 1;
    localparam int VEC_AW     = (VEC_SLOTS > 1) ? $clog2(VEC_SLOTS) : 1;
    localparam int NBR_CNT_W  = $clog2(NBR_SLOTS + 1);
    localparam int VEC_CNT_W  = $clog2(VEC_SLOTS + 1);
    localparam int SCAN_W     = (NBR_CNT_W > VEC_CNT_W) ? NBR_CNT_W : VEC_CNT_W;
    localparam int VEC_DATA_W = VEC_BYTES * BYTE_W;
    localparam int PARAM_W    = PARAM_FIELDS * BYTE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON = 8'd1;
    localparam logic [TICK_W-1:0]    EXPIRY_RESET = 32'd32;
    localparam logic [ID_W-1:0]      BEACON_RESET = 8'd0;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
        logic [DIST_W-1:0] distance;
    } nbr_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [VEC_DATA_W-1:0] bytes;
    } vec_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;      // capture the input item
        logic scan_clear;   // restart the table scan
        logic scan_step;    // step the table scan
        logic sel_vec;      // scan works on the vector table
        logic nwrite;       // write the neighbor entry
        logic vwrite;       // write the vector entry
        logic age_init;     // start the sweep at the last entry
        logic age_rd;       // read the entry under the sweep pointer
        logic age_rd_last;  // read the last valid entry
        logic age_move;     // move the last entry into the swept slot
        logic age_drop;     // drop the last entry itself
        logic age_next;     // keep the entry, step down
        logic out_load;     // load the result register
    } nta_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic want_vec;
        logic age_done;
        logic expired;
        logic at_last;
    } nta_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/nta_dpath.sv =====
// datapath of the neighbor table: input capture, config registers, neighbor and vector
// memories, scan and sweep counters, result register; uses nta_pkg
`default_nettype none

module nta_dpath import nta_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire nta_cmd_t                cmd,
    output nta_stat_t                    stat,
    input  wire logic                    cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [TICK_W-1:0]       s_now_ticks,
    input  wire logic [ID_W-1:0]         s_sender_id,
    input  wire logic [DIST_W-1:0]       s_distance_mm,
    input  wire logic                    s_share_flag,
    input  wire logic [BYTE_W-1:0]       s_param_0,
    input  wire logic [BYTE_W-1:0]       s_param_1,
    input  wire logic [BYTE_W-1:0]       s_param_2,
    input  wire logic [BYTE_W-1:0]       s_param_3,
    input  wire logic [BYTE_W-1:0]       s_param_4,
    input  wire logic [BYTE_W-1:0]       s_param_5,
    input  wire logic [BYTE_W-1:0]       s_param_6,
    output logic [NBR_CNT_W-1:0]         m_neighbor_count,
    output logic [VEC_CNT_W-1:0]         m_vector_count,
    output logic [NBR_AW-1:0]            m_neighbor_slot,
    output logic                         m_was_known,
    output logic [NBR_CNT_W-1:0]         m_removed_count
);

    // captured item
    logic [TICK_W-1:0]  now_reg;
    logic [ID_W-1:0]    sender_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               share_reg;
    logic [PARAM_W-1:0] params_reg;

    // config registers
    logic [TICK_W-1:0]  expiry_reg;
    logic [ID_W-1:0]    beacon_reg;

    // table state
    nbr_entry_t               nbr_mem [NBR_SLOTS];
    vec_entry_t               vec_mem [VEC_SLOTS];
    nbr_entry_t               nbr_rd_reg;
    vec_entry_t               vec_rd_reg;
    logic [NBR_CNT_W-1:0]     nbr_count_reg;
    logic [VEC_CNT_W-1:0]     vec_count_reg;

    // scan and sweep control
    logic [SCAN_W-1:0]        idx_reg;
    logic [SCAN_W-1:0]        rd_idx_reg;
    logic                     rdv_reg;
    logic                     found_reg;
    logic [SCAN_W-1:0]        hit_idx_reg;
    logic [NBR_CNT_W-1:0]     k_reg;
    logic [NBR_CNT_W-1:0]     removed_reg;
    logic [NBR_AW-1:0]        nslot_reg;
    logic                     known_reg;

    // result register
    logic [NBR_CNT_W-1:0]     out_ncount_reg;
    logic [VEC_CNT_W-1:0]     out_vcount_reg;
    logic [NBR_AW-1:0]        out_slot_reg;
    logic                     out_known_reg;
    logic [NBR_CNT_W-1:0]     out_removed_reg;

    logic [SCAN_W-1:0]        cur_count;
    logic [ID_W-1:0]          rd_id;
    logic                     scan_hit;
    logic [NBR_CNT_W-1:0]     k_m1;
    logic [NBR_CNT_W-1:0]     count_m1;
    logic [NBR_AW-1:0]        age_idx;
    logic [NBR_AW-1:0]        last_idx;
    logic [TICK_W-1:0]        age;
    logic                     nbr_room;
    logic                     vec_room;
    logic [NBR_AW-1:0]        nslot;
    logic [VEC_AW-1:0]        vslot;
    logic [NBR_AW-1:0]        nbr_raddr;
    logic                     nbr_we;
    logic [NBR_AW-1:0]        nbr_waddr;
    nbr_entry_t               nbr_wdata;

    // scan compare against the entry read last cycle
    assign cur_count = cmd.sel_vec ? SCAN_W'(vec_count_reg) : SCAN_W'(nbr_count_reg);
    assign rd_id     = cmd.sel_vec ? vec_rd_reg.id : nbr_rd_reg.id;
    assign scan_hit  = rdv_reg && (rd_id == sender_reg);

    // sweep addressing and age test
    assign k_m1     = k_reg - 1'b1;
    assign count_m1 = nbr_count_reg - 1'b1;
    assign age_idx  = k_m1[NBR_AW-1:0];
    assign last_idx = count_m1[NBR_AW-1:0];
    assign age      = now_reg - nbr_rd_reg.tick;

    // status to the controller
    assign stat.scan_done = scan_hit || (idx_reg >= cur_count);
    assign stat.want_vec  = share_reg && (sender_reg != beacon_reg);
    assign stat.age_done  = (k_reg == '0);
    assign stat.expired   = (age > expiry_reg);
    assign stat.at_last   = (k_reg == nbr_count_reg);

    // slot choice: match, append, or overwrite the last slot
    assign nbr_room = nbr_count_reg < NBR_CNT_W'(NBR_SLOTS);
    assign vec_room = vec_count_reg < VEC_CNT_W'(VEC_SLOTS);

    always_comb begin
        if (found_reg) begin
            nslot = hit_idx_reg[NBR_AW-1:0];
        end else if (nbr_room) begin
            nslot = nbr_count_reg[NBR_AW-1:0];
        end else begin
            nslot = NBR_AW'(NBR_SLOTS - 1);
        end
        if (found_reg) begin
            vslot = hit_idx_reg[VEC_AW-1:0];
        end else if (vec_room) begin
            vslot = vec_count_reg[VEC_AW-1:0];
        end else begin
            vslot = VEC_AW'(VEC_SLOTS - 1);
        end
    end

    // neighbor memory port selection
    always_comb begin
        if (cmd.age_rd_last) begin
            nbr_raddr = last_idx;
        end else if (cmd.age_rd) begin
            nbr_raddr = age_idx;
        end else begin
            nbr_raddr = idx_reg[NBR_AW-1:0];
        end
        nbr_we    = cmd.nwrite || cmd.age_move;
        nbr_waddr = cmd.age_move ? age_idx : nslot;
        if (cmd.age_move) begin
            nbr_wdata = nbr_rd_reg;
        end else begin
            nbr_wdata.id       = sender_reg;
            nbr_wdata.tick     = now_reg;
            nbr_wdata.distance = dist_reg;
        end
    end

    // neighbor memory, registered read
    always_ff @(posedge aclk) begin
        if (nbr_we) begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        nbr_rd_reg <= nbr_mem[nbr_raddr];
    end

    // vector memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.vwrite) begin
            vec_mem[vslot] <= '{id: sender_reg, bytes: params_reg[VEC_DATA_W-1:0]};
        end
        vec_rd_reg <= vec_mem[idx_reg[VEC_AW-1:0]];
    end

    // item capture and result register
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg    <= s_now_ticks;
            sender_reg <= s_sender_id;
            dist_reg   <= s_distance_mm;
            share_reg  <= s_share_flag;
            params_reg <= {s_param_6, s_param_5, s_param_4, s_param_3,
                           s_param_2, s_param_1, s_param_0};
        end
        if (cmd.out_load) begin
            out_ncount_reg  <= nbr_count_reg;
            out_vcount_reg  <= vec_count_reg;
            out_slot_reg    <= nslot_reg;
            out_known_reg   <= known_reg;
            out_removed_reg <= removed_reg;
        end
    end

    // counts, config and sequencing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg    <= EXPIRY_RESET;
            beacon_reg    <= BEACON_RESET;
            nbr_count_reg <= '0;
            vec_count_reg <= '0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
        end else begin
            // config write, unknown indexes ignored
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_EXPIRY: expiry_reg <= cfg_data[TICK_W-1:0];
                    CFG_BEACON: beacon_reg <= cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end

            // item start
            if (cmd.load_in) begin
                removed_reg <= '0;
                nslot_reg   <= '0;
                known_reg   <= 1'b0;
            end

            // table scan
            if (cmd.scan_clear) begin
                idx_reg <= '0;
                rdv_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                if (stat.scan_done) begin
                    rdv_reg     <= 1'b0;
                    found_reg   <= scan_hit;
                    hit_idx_reg <= rd_idx_reg;
                end else begin
                    rdv_reg    <= 1'b1;
                    rd_idx_reg <= idx_reg;
                    idx_reg    <= idx_reg + 1'b1;
                end
            end

            // message writes
            if (cmd.nwrite) begin
                nslot_reg <= nslot;
                known_reg <= found_reg;
                if (!found_reg && nbr_room) begin
                    nbr_count_reg <= nbr_count_reg + 1'b1;
                end
            end
            if (cmd.vwrite && !found_reg && vec_room) begin
                vec_count_reg <= vec_count_reg + 1'b1;
            end

            // aging sweep
            if (cmd.age_init) begin
                k_reg <= nbr_count_reg;
            end else if (cmd.age_move || cmd.age_drop) begin
                nbr_count_reg <= count_m1;
                removed_reg   <= removed_reg + 1'b1;
                k_reg         <= k_m1;
            end else if (cmd.age_next) begin
                k_reg <= k_m1;
            end
        end
    end

    assign m_neighbor_count = out_ncount_reg;
    assign m_vector_count   = out_vcount_reg;
    assign m_neighbor_slot  = out_slot_reg;
    assign m_was_known      = out_known_reg;
    assign m_removed_count  = out_removed_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nta_ctrl.sv =====
// controller of the neighbor table: state machine over scan, write and aging steps,
// input and result handshakes; uses nta_pkg
`default_nettype none

module nta_ctrl import nta_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_mode,
    output logic            m_valid,
    input  wire logic       m_ready,
    output nta_cmd_t        cmd,
    input  wire nta_stat_t  stat
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_NSCAN  = 9'b000000010,
        S_NWRITE = 9'b000000100,
        S_VSCAN  = 9'b000001000,
        S_VWRITE = 9'b000010000,
        S_AREAD  = 9'b000100000,
        S_ACHK   = 9'b001000000,
        S_AMOVE  = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    cmd.age_init   = 1'b1;
                    state_next     = s_mode ? S_AREAD : S_NSCAN;
                end
            end
            S_NSCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_NWRITE;
                end
            end
            S_NWRITE: begin
                cmd.nwrite     = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = stat.want_vec ? S_VSCAN : S_RESULT;
            end
            S_VSCAN: begin
                cmd.scan_step = 1'b1;
                cmd.sel_vec   = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_VWRITE;
                end
            end
            S_VWRITE: begin
                cmd.vwrite = 1'b1;
                state_next = S_RESULT;
            end
            S_AREAD: begin
                if (stat.age_done) begin
                    state_next = S_RESULT;
                end else begin
                    cmd.age_rd = 1'b1;
                    state_next = S_ACHK;
                end
            end
            S_ACHK: begin
                // expired entry: fetch the last one to fill the hole, or just drop the last
                if (!stat.expired) begin
                    cmd.age_next = 1'b1;
                    state_next   = S_AREAD;
                end else if (stat.at_last) begin
                    cmd.age_drop = 1'b1;
                    state_next   = S_AREAD;
                end else begin
                    cmd.age_rd_last = 1'b1;
                    state_next      = S_AMOVE;
                end
            end
            S_AMOVE: begin
                cmd.age_move = 1'b1;
                state_next   = S_AREAD;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/neighbor_table_with_aging.sv =====
// top level of the neighbor table with aging: joins the controller and the datapath
// uses nta_pkg, nta_ctrl, nta_dpath
`default_nettype none

// Usage
//   Input channel s_*: one item per handshake. s_mode 0 is a received message that looks
//   up the sender, refreshes or appends its neighbor entry and, when sharing is allowed
//   and the sender is not the beacon, stores its parameter bytes. s_mode 1 is an aging
//   sweep that removes entries older than the expiry.
//   Result channel m_*: exactly one item per input item, in order.
//   Config channel cfg_*: always ready; index 0 is the expiry, index 1 the beacon id.
//   Write it only while no item is in flight.
// Sequencing (one item at a time)
//   message: the neighbor scan and write, then the vector scan and write when the
//   parameter bytes are stored, then the result; the scans walk the neighbor and vector
//   memories one entry per cycle through their single read port.
//   sweep: each entry is read and checked, last first; a hole is filled with the last.
//   The next item is accepted the cycle after the result is loaded.
// Reset clears both counts, loads expiry 32 and beacon 0; table contents are not cleared.
// A stalled receiver holds the result; one finished item may wait in the controller.
module neighbor_table_with_aging import nta_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_mode,
    input  wire logic [TICK_W-1:0]       s_now_ticks,
    input  wire logic [ID_W-1:0]         s_sender_id,
    input  wire logic [DIST_W-1:0]       s_distance_mm,
    input  wire logic                    s_share_flag,
    input  wire logic [BYTE_W-1:0]       s_param_0,
    input  wire logic [BYTE_W-1:0]       s_param_1,
    input  wire logic [BYTE_W-1:0]       s_param_2,
    input  wire logic [BYTE_W-1:0]       s_param_3,
    input  wire logic [BYTE_W-1:0]       s_param_4,
    input  wire logic [BYTE_W-1:0]       s_param_5,
    input  wire logic [BYTE_W-1:0]       s_param_6,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [NBR_CNT_W-1:0]         m_neighbor_count,
    output logic [VEC_CNT_W-1:0]         m_vector_count,
    output logic [NBR_AW-1:0]            m_neighbor_slot,
    output logic                         m_was_known,
    output logic [NBR_CNT_W-1:0]         m_removed_count
);

    nta_cmd_t  cmd;
    nta_stat_t stat;

    // config registers take a write every cycle
    assign cfg_ready = 1'b1;

    nta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    nta_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_now_ticks      (s_now_ticks),
        .s_sender_id      (s_sender_id),
        .s_distance_mm    (s_distance_mm),
        .s_share_flag     (s_share_flag),
        .s_param_0        (s_param_0),
        .s_param_1        (s_param_1),
        .s_param_2        (s_param_2),
        .s_param_3        (s_param_3),
        .s_param_4        (s_param_4),
        .s_param_5        (s_param_5),
        .s_param_6        (s_param_6),
        .m_neighbor_count (m_neighbor_count),
        .m_vector_count   (m_vector_count),
        .m_neighbor_slot  (m_neighbor_slot),
        .m_was_known      (m_was_known),
        .m_removed_count  (m_removed_count)
    );

endmodule

`default_nettype wire

// ===== rtl/core/nta_checker.sv =====
// port-level checks on the neighbor table with aging, attached to the top level by bind
// uses nta_pkg
`default_nettype none

module nta_checker import nta_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [NBR_CNT_W-1:0] m_neighbor_count,
    input wire logic [VEC_CNT_W-1:0] m_vector_count,
    input wire logic [NBR_AW-1:0]    m_neighbor_slot,
    input wire logic                 m_was_known,
    input wire logic [NBR_CNT_W-1:0] m_removed_count
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // counts never exceed the table sizes
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_neighbor_count <= NBR_CNT_W'(NBR_SLOTS))
                    && (m_vector_count <= VEC_CNT_W'(VEC_SLOTS)))
        else $error("table count out of range");

    // a sweep result that removed entries carries no slot and no known flag
    a_sweep_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_removed_count != '0) |-> !m_was_known && (m_neighbor_slot == '0))
        else $error("sweep result with message fields set");

    // a refreshed entry lies inside the valid part of the table
    a_known_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_known |-> (NBR_CNT_W'(m_neighbor_slot) < m_neighbor_count))
        else $error("known sender slot beyond neighbor count");

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_neighbor_count (m_neighbor_count),
    .m_vector_count   (m_vector_count),
    .m_neighbor_slot  (m_neighbor_slot),
    .m_was_known      (m_was_known),
    .m_removed_count  (m_removed_count)
);

`default_nettype wire
